/* design/olsu_pkg.sv */
// Shared sizes, types and codes for the ordered list store.
package olsu_pkg;

    localparam int DEPTH    = 16;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int DATA_W   = 32;
    localparam int POS_W    = 4;
    localparam int LEN_W    = 5;
    localparam int STATUS_W = 3;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [DATA_W-1:0]   data_t;
    typedef logic [POS_W-1:0]    pos_t;
    typedef logic [LEN_W-1:0]    len_t;
    typedef logic [CMP_W-1:0]    cmp_t;

    typedef enum logic [1:0] {
        OP_APPEND    = 2'd0,
        OP_DEL_VALUE = 2'd1,
        OP_DEL_INDEX = 2'd2,
        OP_SEARCH    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        RS_OK        = 3'd0,
        RS_EMPTY     = 3'd1,
        RS_NOT_FOUND = 3'd2,
        RS_BAD_INDEX = 3'd3,
        RS_FULL      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_FETCH,
        ST_SHIFT,
        ST_DONE
    } state_t;

endpackage

/* design/olsu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module olsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/ordered_list_store_unit.sv */
// Ordered list store: packed list of signed words with append, delete and search.
//
// The list lives in one RAM with a single write and a single registered read port,
// and a small sequencer walks it one entry per cycle. An append writes its entry
// straight from dispatch; a search reads entries in order until it hits or reaches
// the end; a delete by value walks to the entry, a delete by index reads it directly,
// and either then moves every later entry down one place through the same RAM port.
// One request is worked on at a time and s_ready is high only while the sequencer
// is idle; a finished result waits in an output register, so a new request is taken
// while the previous result is still unclaimed. After reset the list is empty and no
// clearing pass is needed.
module ordered_list_store_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_op,
    input  logic signed [olsu_pkg::DATA_W-1:0]  s_value,
    input  logic [olsu_pkg::POS_W-1:0]          s_position,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [olsu_pkg::STATUS_W-1:0]       m_status,
    output logic signed [olsu_pkg::DATA_W-1:0]  m_result_value,
    output logic [olsu_pkg::POS_W-1:0]          m_found_index,
    output logic [olsu_pkg::LEN_W-1:0]          m_length
);

    olsu_pkg::state_t  state_reg, state_next;
    olsu_pkg::op_t     op_reg;
    olsu_pkg::data_t   value_reg;
    olsu_pkg::pos_t    pos_reg;
    olsu_pkg::cnt_t    count_reg, count_next;
    olsu_pkg::cnt_t    ptr_reg, ptr_next;
    logic              pend_reg, pend_next;
    olsu_pkg::cnt_t    pend_idx_reg, pend_idx_next;
    olsu_pkg::status_t status_reg, status_next;
    olsu_pkg::data_t   rv_reg, rv_next;
    olsu_pkg::pos_t    fi_reg, fi_next;

    logic                          m_valid_reg, m_valid_next;
    logic [olsu_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    olsu_pkg::data_t               m_result_value_reg, m_result_value_next;
    olsu_pkg::pos_t                m_found_index_reg, m_found_index_next;
    olsu_pkg::len_t                m_length_reg, m_length_next;

    logic            ram_we;
    olsu_pkg::addr_t ram_waddr;
    olsu_pkg::data_t ram_wdata;
    logic            ram_re;
    olsu_pkg::addr_t ram_raddr;
    olsu_pkg::data_t ram_rdata;

    logic s_accept;
    logic hit;

    olsu_ram #(
        .WIDTH(olsu_pkg::DATA_W),
        .DEPTH(olsu_pkg::DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready  = (state_reg == olsu_pkg::ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign hit      = pend_reg && (ram_rdata == value_reg);

    // request word, held for the whole operation
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg    <= olsu_pkg::op_t'(s_op);
            value_reg <= s_value;
            pos_reg   <= s_position;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= olsu_pkg::ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg            <= ptr_next;
        pend_idx_reg       <= pend_idx_next;
        status_reg         <= status_next;
        rv_reg             <= rv_next;
        fi_reg             <= fi_next;
        m_status_reg       <= m_status_next;
        m_result_value_reg <= m_result_value_next;
        m_found_index_reg  <= m_found_index_next;
        m_length_reg       <= m_length_next;
    end

    always_comb begin
        state_next          = state_reg;
        count_next          = count_reg;
        ptr_next            = ptr_reg;
        pend_next           = pend_reg;
        pend_idx_next       = pend_idx_reg;
        status_next         = status_reg;
        rv_next             = rv_reg;
        fi_next             = fi_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_status_next       = m_status_reg;
        m_result_value_next = m_result_value_reg;
        m_found_index_next  = m_found_index_reg;
        m_length_next       = m_length_reg;
        ram_we              = 1'b0;
        ram_waddr           = olsu_pkg::addr_t'(count_reg);
        ram_wdata           = value_reg;
        ram_re              = 1'b0;
        ram_raddr           = olsu_pkg::addr_t'(ptr_reg);

        unique case (state_reg)
            olsu_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = olsu_pkg::ST_DISPATCH;
                end
            end

            olsu_pkg::ST_DISPATCH: begin
                status_next = olsu_pkg::RS_OK;
                rv_next     = '0;
                fi_next     = '0;
                ptr_next    = '0;
                pend_next   = 1'b0;
                unique case (op_reg)
                    olsu_pkg::OP_APPEND: begin
                        if (count_reg == olsu_pkg::cnt_t'(olsu_pkg::DEPTH)) begin
                            status_next = olsu_pkg::RS_FULL;
                        end else begin
                            ram_we     = 1'b1;
                            count_next = count_reg + olsu_pkg::cnt_t'(1);
                        end
                        state_next = olsu_pkg::ST_DONE;
                    end
                    olsu_pkg::OP_DEL_VALUE: begin
                        if (count_reg == '0) begin
                            status_next = olsu_pkg::RS_EMPTY;
                            state_next  = olsu_pkg::ST_DONE;
                        end else begin
                            state_next = olsu_pkg::ST_SCAN;
                        end
                    end
                    olsu_pkg::OP_DEL_INDEX: begin
                        if (count_reg == '0) begin
                            status_next = olsu_pkg::RS_EMPTY;
                            state_next  = olsu_pkg::ST_DONE;
                        end else if (olsu_pkg::cmp_t'(pos_reg)
                                     >= olsu_pkg::cmp_t'(count_reg)) begin
                            status_next = olsu_pkg::RS_BAD_INDEX;
                            state_next  = olsu_pkg::ST_DONE;
                        end else begin
                            ram_re     = 1'b1;
                            ram_raddr  = olsu_pkg::addr_t'(pos_reg);
                            state_next = olsu_pkg::ST_FETCH;
                        end
                    end
                    olsu_pkg::OP_SEARCH: begin
                        state_next = olsu_pkg::ST_SCAN;
                    end
                endcase
            end

            // compare the entry read last cycle while the next read goes out
            olsu_pkg::ST_SCAN: begin
                if (hit) begin
                    if (op_reg == olsu_pkg::OP_SEARCH) begin
                        rv_next    = value_reg;
                        fi_next    = olsu_pkg::pos_t'(pend_idx_reg);
                        state_next = olsu_pkg::ST_DONE;
                    end else begin
                        rv_next    = ram_rdata;
                        ptr_next   = pend_idx_reg + olsu_pkg::cnt_t'(1);
                        pend_next  = 1'b0;
                        state_next = olsu_pkg::ST_SHIFT;
                    end
                end else if (ptr_reg < count_reg) begin
                    ram_re        = 1'b1;
                    ptr_next      = ptr_reg + olsu_pkg::cnt_t'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = ptr_reg;
                end else begin
                    status_next = olsu_pkg::RS_NOT_FOUND;
                    pend_next   = 1'b0;
                    state_next  = olsu_pkg::ST_DONE;
                end
            end

            olsu_pkg::ST_FETCH: begin
                rv_next    = ram_rdata;
                ptr_next   = olsu_pkg::cnt_t'(pos_reg) + olsu_pkg::cnt_t'(1);
                pend_next  = 1'b0;
                state_next = olsu_pkg::ST_SHIFT;
            end

            // move each later entry down one place, one per cycle
            olsu_pkg::ST_SHIFT: begin
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = olsu_pkg::addr_t'(pend_idx_reg - olsu_pkg::cnt_t'(1));
                    ram_wdata = ram_rdata;
                end
                if (ptr_reg < count_reg) begin
                    ram_re        = 1'b1;
                    ptr_next      = ptr_reg + olsu_pkg::cnt_t'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = ptr_reg;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        count_next = count_reg - olsu_pkg::cnt_t'(1);
                        state_next = olsu_pkg::ST_DONE;
                    end
                end
            end

            // hold the result until the output register is free
            olsu_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_status_next       = status_reg;
                    m_result_value_next = rv_reg;
                    m_found_index_next  = fi_reg;
                    m_length_next       = olsu_pkg::len_t'(count_reg);
                    state_next          = olsu_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = olsu_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_result_value = m_result_value_reg;
    assign m_found_index  = m_found_index_reg;
    assign m_length       = m_length_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= olsu_pkg::cnt_t'(olsu_pkg::DEPTH))
        else $error("entry count above depth");

    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == olsu_pkg::ST_DISPATCH && op_reg == olsu_pkg::OP_APPEND
         && count_reg < olsu_pkg::cnt_t'(olsu_pkg::DEPTH))
        |=> count_reg == $past(count_reg) + olsu_pkg::cnt_t'(1))
        else $error("append did not grow the list");

    a_shift_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == olsu_pkg::ST_SHIFT && pend_reg)
        |-> (pend_idx_reg < count_reg && pend_idx_reg != '0))
        else $error("shift write outside the list");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == olsu_pkg::ST_SCAN && ram_re) |-> ptr_reg < count_reg)
        else $error("scan read outside the list");

    a_result_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == olsu_pkg::ST_DONE && (!m_valid_reg || m_ready))
        |=> (m_valid_reg && state_reg == olsu_pkg::ST_IDLE))
        else $error("finished result not issued");

endmodule
